// ===== sv/midpoint_line_rasterizer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define LNR_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LNR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// next-cycle implication, live through reset
`define LNR_ASSERT_RESET(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/lnr_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Widths, codes and shared types of the line rasterizer.
// ----------------------------------------------------------------------------
package lnr_pkg;

  localparam int COORD_BITS = 9;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int INC_BITS   = COORD_BITS + 2;
  localparam int STEP_BITS  = COORD_BITS + 1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic signed [DEC_BITS-1:0]  dec_t;
  typedef logic signed [INC_BITS-1:0]  inc_t;
  typedef logic [STEP_BITS-1:0]        step_t;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_STEEP_UP     = 2'd1,
    OCT_SHALLOW_DOWN = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } octant_t;

  typedef struct packed {
    octant_t octant;
    coord_t  x;
    coord_t  y;
    dec_t    decision;
    inc_t    straight_inc;
    inc_t    diagonal_inc;
    step_t   steps;
    logic    empty;
  } lnr_setup_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   pixel_valid;
    logic   last_pixel;
  } lnr_pixel_t;

endpackage

// ===== sv/lnr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer request channel
// Valid/ready channel carrying load and step requests.
// ----------------------------------------------------------------------------
interface lnr_cmd_if import lnr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   func;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output func, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink   (input valid, input func, input start_x, input start_y,
                  input end_x, input end_y, output ready);
endinterface

// ===== sv/lnr_pix_if.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer pixel channel
// Valid/ready channel carrying one pixel result per step request.
// ----------------------------------------------------------------------------
interface lnr_pix_if import lnr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   pixel_valid;
  logic   last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_valid,
                  output last_pixel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_valid,
                  input last_pixel, output ready);
endinterface

// ===== sv/lnr_setup.sv =====
// ----------------------------------------------------------------------------
// Line setup
// Orders the endpoints, picks the octant case and builds the decision
// variable, its two increments and the pixel count.
// ----------------------------------------------------------------------------
module lnr_setup import lnr_pkg::*; (
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  output lnr_setup_t setup
);

  localparam int PAD = DEC_BITS - COORD_BITS;

  logic   swap;
  coord_t lx, ly, rx, ry;
  dec_t   dx, dy, ady, half_dx, half_dy, half_ady;
  dec_t   d, s, g, n;

  assign swap = start_x > end_x;
  assign lx   = swap ? end_x   : start_x;
  assign ly   = swap ? end_y   : start_y;
  assign rx   = swap ? start_x : end_x;
  assign ry   = swap ? start_y : end_y;

  assign dx       = $signed({{PAD{1'b0}}, rx}) - $signed({{PAD{1'b0}}, lx});
  assign dy       = $signed({{PAD{1'b0}}, ry}) - $signed({{PAD{1'b0}}, ly});
  assign ady      = -dy;
  assign half_dx  = dx >>> 1;
  assign half_dy  = dy >>> 1;
  assign half_ady = ady >>> 1;

  always_comb begin
    setup       = '0;
    setup.x     = lx;
    setup.y     = ly;
    setup.empty = (dx == '0) && (dy == '0);
    if (!dy[DEC_BITS-1] && dy <= dx) begin
      setup.octant = OCT_SHALLOW_UP;
      d = dy - half_dx;
      s = dy;
      g = dy - dx;
      n = dx;
    end else if (dy > dx) begin
      setup.octant = OCT_STEEP_UP;
      d = half_dy - dx;
      s = -dx;
      g = dy - dx;
      n = dy;
    end else if (ady <= dx) begin
      setup.octant = OCT_SHALLOW_DOWN;
      d = dy + half_dx;
      s = dy;
      g = dy + dx;
      n = dx;
    end else begin
      setup.octant = OCT_STEEP_DOWN;
      setup.x      = rx;
      setup.y      = ry;
      d = dx - half_ady;
      s = dx;
      g = dx - ady;
      n = ady;
    end
    setup.decision     = d;
    setup.straight_inc = s[INC_BITS-1:0];
    setup.diagonal_inc = g[INC_BITS-1:0];
    setup.steps        = n[STEP_BITS-1:0];
  end

endmodule

// ===== sv/lnr_core.sv =====
// ----------------------------------------------------------------------------
// Line stepper
// Registers each request, then loads a new line or emits the next pixel
// and advances the decision variable.
// ----------------------------------------------------------------------------
module lnr_core import lnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lnr_cmd_if.sink     cmd,
  input  logic        space,
  output logic        push,
  output lnr_pixel_t  pixel
);

  logic       req_valid;
  logic       req_func;
  coord_t     req_start_x, req_start_y, req_end_x, req_end_y;
  logic       adv;

  coord_t     cur_x, cur_y;
  dec_t       decision;
  inc_t       straight_inc, diagonal_inc;
  octant_t    octant_case;
  step_t      steps_left;
  logic       busy;

  lnr_setup_t setup;
  logic       active;
  logic       diag;
  dec_t       decision_next;
  coord_t     cur_x_next, cur_y_next;

  lnr_setup u_setup (
    .start_x (req_start_x),
    .start_y (req_start_y),
    .end_x   (req_end_x),
    .end_y   (req_end_y),
    .setup   (setup)
  );

  assign adv       = req_valid && (req_func == FUNC_LOAD || space);
  assign cmd.ready = !req_valid || adv;
  assign push      = adv && req_func == FUNC_STEP;
  assign active    = busy && steps_left != '0;

  always_comb begin
    case (octant_case)
      OCT_SHALLOW_UP, OCT_STEEP_DOWN:   diag = !decision[DEC_BITS-1];
      OCT_STEEP_UP, OCT_SHALLOW_DOWN:   diag = decision[DEC_BITS-1] || decision == '0;
      default:                          diag = 1'b0;
    endcase
    decision_next = decision + dec_t'(diag ? diagonal_inc : straight_inc);
    cur_x_next    = cur_x;
    cur_y_next    = cur_y;
    case (octant_case)
      OCT_SHALLOW_UP: begin
        cur_x_next = cur_x + 1'b1;
        if (diag) cur_y_next = cur_y + 1'b1;
      end
      OCT_STEEP_UP: begin
        cur_y_next = cur_y + 1'b1;
        if (diag) cur_x_next = cur_x + 1'b1;
      end
      OCT_SHALLOW_DOWN: begin
        cur_x_next = cur_x + 1'b1;
        if (diag) cur_y_next = cur_y - 1'b1;
      end
      default: begin
        cur_y_next = cur_y + 1'b1;
        if (diag) cur_x_next = cur_x - 1'b1;
      end
    endcase
  end

  always_comb begin
    pixel = '0;
    if (active) begin
      pixel.pixel_x     = cur_x;
      pixel.pixel_y     = cur_y;
      pixel.pixel_valid = 1'b1;
      pixel.last_pixel  = steps_left == step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      req_func    <= cmd.func;
      req_start_x <= cmd.start_x;
      req_start_y <= cmd.start_y;
      req_end_x   <= cmd.end_x;
      req_end_y   <= cmd.end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid    <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      decision     <= '0;
      straight_inc <= '0;
      diagonal_inc <= '0;
      octant_case  <= OCT_SHALLOW_UP;
      steps_left   <= '0;
      busy         <= 1'b0;
    end else begin
      if (cmd.ready) req_valid <= cmd.valid;
      if (adv) begin
        if (req_func == FUNC_LOAD) begin
          if (setup.empty) begin
            busy       <= 1'b0;
            steps_left <= '0;
          end else begin
            octant_case  <= setup.octant;
            cur_x        <= setup.x;
            cur_y        <= setup.y;
            decision     <= setup.decision;
            straight_inc <= setup.straight_inc;
            diagonal_inc <= setup.diagonal_inc;
            steps_left   <= setup.steps;
            busy         <= 1'b1;
          end
        end else if (active) begin
          cur_x      <= cur_x_next;
          cur_y      <= cur_y_next;
          decision   <= decision_next;
          steps_left <= steps_left - 1'b1;
          if (steps_left == step_t'(1)) busy <= 1'b0;
        end else begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/lnr_out_buf.sv =====
// ----------------------------------------------------------------------------
// Pixel output buffer
// Output register with a skid entry behind it, so the stepper keeps
// running while a pixel waits for the downstream side.
// ----------------------------------------------------------------------------
module lnr_out_buf import lnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lnr_pixel_t  data,
  output logic        space,
  lnr_pix_if.source   pixel
);

  lnr_pixel_t head, second;
  logic       head_valid, second_valid;
  logic       pop;

  assign pop   = head_valid && pixel.ready;
  assign space = !second_valid;

  assign pixel.valid       = head_valid;
  assign pixel.pixel_x     = head.pixel_x;
  assign pixel.pixel_y     = head.pixel_y;
  assign pixel.pixel_valid = head.pixel_valid;
  assign pixel.last_pixel  = head.last_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid   <= 1'b0;
      second_valid <= 1'b0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (!head_valid) head_valid <= 1'b1;
          else second_valid <= 1'b1;
        end
        2'b01: begin
          if (second_valid) second_valid <= 1'b0;
          else head_valid <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (!head_valid) head <= data;
        else second <= data;
      end
      2'b11: head <= data;
      2'b01: begin
        if (second_valid) head <= second;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/midpoint_line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Loads two endpoints and walks the line one pixel per step request.
// ----------------------------------------------------------------------------
// One request is taken every clock unless a step request waits for output
// buffer space. A load request (func 0) sets up a new line and gives no
// result; a step request (func 1) gives exactly one result, the next pixel
// with its last flag, or a not-valid result once the line is done or empty.
// The endpoint at which the walk ends is never emitted. A request is held
// in the input register, where the endpoint setup and the stepper's single
// add on the decision variable run and set the one-pixel-per-clock rate;
// its result goes from there into the output register. A two-entry output
// buffer keeps requests flowing while the pixel side stalls; step requests
// stop only once both entries are full.
module midpoint_line_rasterizer_top import lnr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lnr_cmd_if.sink    cmd,
  lnr_pix_if.source  pixel
);

  logic       push;
  logic       space;
  lnr_pixel_t pix_data;

  lnr_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .space (space),
    .push  (push),
    .pixel (pix_data)
  );

  lnr_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .data  (pix_data),
    .space (space),
    .pixel (pixel)
  );

endmodule

// ===== sv/lnr_checker.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer port checker
// Watches the top level ports for reset, hold and result coding rules.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_top_defines.svh"

module lnr_checker import lnr_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   cmd_ready,
  input logic   pix_valid,
  input logic   pix_ready,
  input coord_t pixel_x,
  input coord_t pixel_y,
  input logic   pixel_valid,
  input logic   last_pixel
);

  logic                    stall;
  logic                    no_pixel;
  logic [2*COORD_BITS+1:0] pix_word;

  assign stall    = pix_valid && !pix_ready;
  assign no_pixel = pix_valid && !pixel_valid;
  assign pix_word = {pixel_x, pixel_y, pixel_valid, last_pixel};

  `LNR_ASSERT_RESET(a_reset_empty, rst, !pix_valid && cmd_ready, "not empty after reset")

  `LNR_ASSERT_NEXT(a_pix_hold, stall, pix_valid && $stable(pix_word), "pixel not held")

  `LNR_ASSERT_NOW(a_last_valid, pix_valid && last_pixel, pixel_valid, "last on empty result")

  `LNR_ASSERT_NOW(a_idle_zero, no_pixel, pixel_x == '0 && pixel_y == '0, "empty result not zero")

endmodule

bind midpoint_line_rasterizer_top lnr_checker u_lnr_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .pix_valid   (pixel.valid),
  .pix_ready   (pixel.ready),
  .pixel_x     (pixel.pixel_x),
  .pixel_y     (pixel.pixel_y),
  .pixel_valid (pixel.pixel_valid),
  .last_pixel  (pixel.last_pixel)
);
